@@ rtl/bicolor_matrix_frame_buffer_unit_defines.svh @@
// assertion macros for the bicolor matrix frame buffer
// expects clk and arst_n in the scope where a macro is used
`ifndef BICOLOR_MATRIX_FRAME_BUFFER_UNIT_DEFINES_SVH
`define BICOLOR_MATRIX_FRAME_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define BMFB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMFB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bmfb_pkg.sv @@
// shared types, command codes, font rom and microcode rom of the frame buffer
// no dependencies
package bmfb_pkg;

	localparam int STORE_BYTES = 16;
	localparam int STORED_ROWS = 8;
	localparam int ROWS_DEF    = 8;
	localparam int GLYPH_W     = 3;
	localparam int GLYPH_H     = 5;
	localparam int TENS_COL    = 0;
	localparam int ONES_COL    = 4;
	localparam int NUM_MAX     = 99;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [7:0]         byte_t;
	typedef logic [2:0]         cmd_code_t;
	typedef logic [2:0]         coord_t;
	typedef logic [1:0]         color_t;
	typedef logic signed [7:0]  number_t;
	typedef logic [3:0]         digit_t;
	typedef logic [3:0]         step_t;

	localparam byte_t ADDR_BYTE = 8'h00;

	localparam cmd_code_t CMD_SET_PIXEL   = 3'd0;
	localparam cmd_code_t CMD_SHIFT_ROW   = 3'd1;
	localparam cmd_code_t CMD_CLEAR       = 3'd2;
	localparam cmd_code_t CMD_DRAW_NUMBER = 3'd3;
	localparam cmd_code_t CMD_REFRESH     = 3'd4;

	// microcode addresses
	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_PIX_G = 4'd1;
	localparam step_t STEP_PIX_R = 4'd2;
	localparam step_t STEP_SHR_G = 4'd3;
	localparam step_t STEP_SHR_R = 4'd4;
	localparam step_t STEP_CLEAR = 4'd5;
	localparam step_t STEP_CHECK = 4'd6;
	localparam step_t STEP_BLIT  = 4'd7;
	localparam step_t STEP_HDR   = 4'd8;
	localparam step_t STEP_EMIT  = 4'd9;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_PIX_G,
		UOP_PIX_R,
		UOP_SHR_G,
		UOP_SHR_R,
		UOP_CLEAR,
		UOP_BLIT,
		UOP_EMIT_HDR,
		UOP_EMIT_BYTE
	} uop_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_END,
		SEQ_LOOP,
		SEQ_CHECK
	} seq_t;

	typedef enum logic {
		LIM_BLIT,
		LIM_STORE
	} lim_t;

	typedef struct packed {
		uop_t uop;
		seq_t seq;
		lim_t lim;
	} ucw_t;

	// 3x5 font, bit c of a row is column c
	localparam logic [GLYPH_W-1:0] GLYPH_ROM [10][GLYPH_H] = '{
		'{3'h6, 3'h5, 3'h5, 3'h5, 3'h3},
		'{3'h2, 3'h3, 3'h2, 3'h2, 3'h7},
		'{3'h7, 3'h1, 3'h2, 3'h4, 3'h7},
		'{3'h7, 3'h4, 3'h6, 3'h4, 3'h7},
		'{3'h5, 3'h5, 3'h7, 3'h4, 3'h4},
		'{3'h7, 3'h1, 3'h7, 3'h4, 3'h3},
		'{3'h6, 3'h1, 3'h7, 3'h5, 3'h3},
		'{3'h7, 3'h4, 3'h2, 3'h1, 3'h1},
		'{3'h6, 3'h5, 3'h7, 3'h5, 3'h3},
		'{3'h6, 3'h5, 3'h7, 3'h4, 3'h3}
	};

	function automatic ucw_t ucode(input step_t s);
		case (s)
			STEP_IDLE:  return '{UOP_NOP,       SEQ_END,   LIM_STORE};
			STEP_PIX_G: return '{UOP_PIX_G,     SEQ_NEXT,  LIM_STORE};
			STEP_PIX_R: return '{UOP_PIX_R,     SEQ_END,   LIM_STORE};
			STEP_SHR_G: return '{UOP_SHR_G,     SEQ_NEXT,  LIM_STORE};
			STEP_SHR_R: return '{UOP_SHR_R,     SEQ_END,   LIM_STORE};
			STEP_CLEAR: return '{UOP_CLEAR,     SEQ_END,   LIM_STORE};
			STEP_CHECK: return '{UOP_NOP,       SEQ_CHECK, LIM_STORE};
			STEP_BLIT:  return '{UOP_BLIT,      SEQ_LOOP,  LIM_BLIT};
			STEP_HDR:   return '{UOP_EMIT_HDR,  SEQ_NEXT,  LIM_STORE};
			STEP_EMIT:  return '{UOP_EMIT_BYTE, SEQ_LOOP,  LIM_STORE};
			default:    return '{UOP_NOP,       SEQ_END,   LIM_STORE};
		endcase
	endfunction

	// program entry per command, unknown commands stay idle
	function automatic step_t entry(input cmd_code_t c);
		case (c)
			CMD_SET_PIXEL:   return STEP_PIX_G;
			CMD_SHIFT_ROW:   return STEP_SHR_G;
			CMD_CLEAR:       return STEP_CLEAR;
			CMD_DRAW_NUMBER: return STEP_CHECK;
			CMD_REFRESH:     return STEP_HDR;
			default:         return STEP_IDLE;
		endcase
	endfunction

endpackage

@@ rtl/bmfb_cmd_if.sv @@
// command channel of the frame buffer: valid/ready plus command fields
// depends on bmfb_pkg
interface bmfb_cmd_if;
	import bmfb_pkg::*;

	logic      valid;
	logic      ready;
	cmd_code_t cmd;
	coord_t    col_x;
	coord_t    row_y;
	color_t    color;
	number_t   number;

	modport source(output valid, output cmd, output col_x, output row_y, output color,
		output number, input ready);
	modport sink(input valid, input cmd, input col_x, input row_y, input color,
		input number, output ready);
endinterface

@@ rtl/bmfb_out_if.sv @@
// byte stream channel of the frame buffer: valid/ready plus byte and last flag
// depends on bmfb_pkg
interface bmfb_out_if;
	import bmfb_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/bicolor_matrix_frame_buffer_unit.sv @@
// Frame buffer for an 8x8 two-color LED matrix: 16 bytes, row r at byte 2r (green)
// and 2r+1 (red), cleared at reset. Commands set pixel, shift row, clear, draw number
// (0 to 99, two 3x5 digits, others ignored) and refresh (address byte 0x00, then the
// 16 store bytes, last set on the final one). A small microcode rom steps a datapath
// that reads and writes one store byte per cycle while no emit step waits on the
// byte stream; clear zeroes all 16 at once. Ready is high only while idle, so a new
// command is taken only once the last one is through; unknown commands do nothing.
// The byte stream has its own output register. Depends on bmfb_pkg, the two channel
// interfaces and bicolor_matrix_frame_buffer_unit_defines.svh.
`include "bicolor_matrix_frame_buffer_unit_defines.svh"

module bicolor_matrix_frame_buffer_unit #(
	parameter int ROWS = bmfb_pkg::ROWS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bmfb_cmd_if.sink   command,
	bmfb_out_if.source stream
);
	import bmfb_pkg::*;

	localparam int    CLIP_ROWS  = (ROWS < STORED_ROWS) ? ROWS : STORED_ROWS;
	localparam int    BLIT_ROWS  = (CLIP_ROWS < GLYPH_H) ? CLIP_ROWS : GLYPH_H;
	localparam addr_t BLIT_LAST  = ADDR_W'(2 * BLIT_ROWS - 1);
	localparam addr_t STORE_LAST = ADDR_W'(STORE_BYTES - 1);
	localparam byte_t GLYPH_MASK = byte_t'(((1 << GLYPH_W) - 1) << TENS_COL)
		| byte_t'(((1 << GLYPH_W) - 1) << ONES_COL);

	step_t   step_q;
	addr_t   idx_q;
	coord_t  col_x_q;
	coord_t  row_y_q;
	color_t  color_q;
	number_t number_q;
	digit_t  tens_q;
	digit_t  ones_q;
	byte_t   store_q [STORE_BYTES];
	logic    out_valid_q;
	byte_t   out_byte_q;
	logic    out_last_q;

	ucw_t    ucw;
	logic    idle;
	logic    cmd_acc;
	logic    emits;
	logic    step_go;
	logic    at_end;
	logic    num_ok;
	addr_t   rd_addr;
	byte_t   rd_byte;
	byte_t   wr_byte;
	byte_t   pix_bit;
	byte_t   blit_bits;
	logic    wr_en;
	logic    clr;
	digit_t  tens_d;
	digit_t  ones_d;
	logic [ADDR_W-2:0] glyph_r;

	assign ucw     = ucode(step_q);
	assign idle    = (step_q == STEP_IDLE);
	assign cmd_acc = command.valid && idle;
	assign emits   = (ucw.uop == UOP_EMIT_HDR) || (ucw.uop == UOP_EMIT_BYTE);
	// an emit step waits until the output register frees up
	assign step_go = !idle && (!emits || !out_valid_q || stream.ready);
	assign at_end  = (idx_q == ((ucw.lim == LIM_BLIT) ? BLIT_LAST : STORE_LAST));
	assign num_ok  = !number_q[7] && (number_q[6:0] <= 7'(NUM_MAX));

	assign command.ready   = idle;
	assign stream.valid    = out_valid_q;
	assign stream.out_byte = out_byte_q;
	assign stream.last     = out_last_q;

	// tens digit by threshold compare, last match wins
	always_comb begin
		tens_d = '0;
		ones_d = number_q[3:0];
		for (int k = 1; k <= 9; k++) begin
			if (number_q[6:0] >= 7'(10 * k)) begin
				tens_d = digit_t'(k);
				ones_d = digit_t'(number_q[6:0] - 7'(10 * k));
			end
		end
	end

	always_comb begin
		case (ucw.uop)
			UOP_PIX_G, UOP_SHR_G: rd_addr = {row_y_q, 1'b0};
			UOP_PIX_R, UOP_SHR_R: rd_addr = {row_y_q, 1'b1};
			default:              rd_addr = idx_q;
		endcase
	end

	assign rd_byte = store_q[rd_addr];
	assign pix_bit = byte_t'(1) << col_x_q;
	assign glyph_r = idx_q[ADDR_W-1:1];
	assign blit_bits = ((byte_t'(GLYPH_ROM[tens_q][glyph_r]) << TENS_COL)
		| (byte_t'(GLYPH_ROM[ones_q][glyph_r]) << ONES_COL)) & GLYPH_MASK;

	always_comb begin
		case (ucw.uop)
			UOP_PIX_G: wr_byte = color_q[0] ? (rd_byte | pix_bit) : (rd_byte & ~pix_bit);
			UOP_PIX_R: wr_byte = color_q[1] ? (rd_byte | pix_bit) : (rd_byte & ~pix_bit);
			UOP_SHR_G, UOP_SHR_R: wr_byte = rd_byte >> 1;
			UOP_BLIT:  wr_byte = blit_bits | (rd_byte & ~GLYPH_MASK);
			default:   wr_byte = rd_byte;
		endcase
	end

	assign wr_en = step_go && ((ucw.uop == UOP_PIX_G) || (ucw.uop == UOP_PIX_R)
		|| (ucw.uop == UOP_SHR_G) || (ucw.uop == UOP_SHR_R) || (ucw.uop == UOP_BLIT));
	assign clr = step_go && (ucw.uop == UOP_CLEAR);

	// sequencer: step counter and loop index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			idx_q  <= '0;
		end else if (cmd_acc) begin
			step_q <= entry(command.cmd);
		end else if (step_go) begin
			case (ucw.seq)
				SEQ_NEXT: step_q <= step_q + 4'd1;
				SEQ_LOOP: begin
					if (at_end) begin
						step_q <= STEP_IDLE;
						idx_q  <= '0;
					end else begin
						idx_q <= idx_q + addr_t'(1);
					end
				end
				SEQ_CHECK: step_q <= num_ok ? (step_q + 4'd1) : STEP_IDLE;
				default: begin
					step_q <= STEP_IDLE;
					idx_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			col_x_q  <= command.col_x;
			row_y_q  <= command.row_y;
			color_q  <= command.color;
			number_q <= command.number;
		end
		if (step_go && (ucw.seq == SEQ_CHECK)) begin
			tens_q <= tens_d;
			ones_q <= ones_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < STORE_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (wr_en) begin
			store_q[rd_addr] <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && emits) begin
			out_valid_q <= 1'b1;
		end else if (stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emits) begin
			out_byte_q <= (ucw.uop == UOP_EMIT_HDR) ? ADDR_BYTE : rd_byte;
			out_last_q <= (ucw.uop == UOP_EMIT_BYTE) && at_end;
		end
	end

	`BMFB_ASSERT_NXT(a_last_ends_burst, step_go && (ucw.uop == UOP_EMIT_BYTE) && at_end,
		(step_q == STEP_IDLE) && out_valid_q && out_last_q, "last byte did not end burst")
	`BMFB_ASSERT_IMP(a_blit_in_range, step_q == STEP_BLIT,
		(idx_q <= BLIT_LAST) && (tens_q <= 4'd9) && (ones_q <= 4'd9), "blit out of range")
	`BMFB_ASSERT_IMP(a_idle_index_zero, idle, idx_q == '0, "loop index left dirty")
	`BMFB_ASSERT_NXT(a_clear_zeroes, clr,
		(store_q[0] == '0) && (store_q[STORE_BYTES-1] == '0), "clear left data")

endmodule

@@ test/tb.sv @@
// testbench for bicolor_matrix_frame_buffer_unit: drives commands, shadows the
// 16-byte frame store and checks every refresh byte and its last flag
// depends on bmfb_pkg, bmfb_cmd_if and bmfb_out_if
`timescale 1ns / 100ps

module tb;
	import bmfb_pkg::*;

	localparam int ROWS_TB       = ROWS_DEF;
	localparam int RANDOM_ITEMS  = 400;
	localparam int LONG_HOLD     = 300;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_REPORTS   = 50;

	localparam cmd_code_t CMD_UNKNOWN_MIN = 3'd5;
	localparam cmd_code_t CMD_UNKNOWN_MID = 3'd6;
	localparam cmd_code_t CMD_UNKNOWN_MAX = 3'd7;

	localparam color_t COLOR_OFF    = 2'd0;
	localparam color_t COLOR_GREEN  = 2'd1;
	localparam color_t COLOR_RED    = 2'd2;
	localparam color_t COLOR_ORANGE = 2'd3;

	// 3x5 digits, bit c of a row lights column c
	localparam logic [2:0] DIGIT_FONT [10][5] = '{
		'{3'h6, 3'h5, 3'h5, 3'h5, 3'h3},
		'{3'h2, 3'h3, 3'h2, 3'h2, 3'h7},
		'{3'h7, 3'h1, 3'h2, 3'h4, 3'h7},
		'{3'h7, 3'h4, 3'h6, 3'h4, 3'h7},
		'{3'h5, 3'h5, 3'h7, 3'h4, 3'h4},
		'{3'h7, 3'h1, 3'h7, 3'h4, 3'h3},
		'{3'h6, 3'h1, 3'h7, 3'h5, 3'h3},
		'{3'h7, 3'h4, 3'h2, 3'h1, 3'h1},
		'{3'h6, 3'h5, 3'h7, 3'h5, 3'h3},
		'{3'h6, 3'h5, 3'h7, 3'h4, 3'h3}
	};

	typedef struct {
		cmd_code_t cmd;
		coord_t    col_x;
		coord_t    row_y;
		color_t    color;
		number_t   number;
	} command_t;

	typedef struct {
		byte_t data;
		logic  last;
	} stream_byte_t;

	typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_RARE} rx_mode_t;

	class frame_scoreboard;
		byte_t        store[STORE_BYTES];
		stream_byte_t pending[$];
		int           errors;
		int           blit_rows;

		function new(int rows);
			blit_rows = (rows < STORED_ROWS) ? rows : STORED_ROWS;
			errors = 0;
			foreach (store[i]) store[i] = '0;
		endfunction

		function void blit(int unsigned digit, int unsigned col);
			byte_t mask;
			byte_t bits;
			mask = byte_t'(8'h07 << col);
			for (int i = 0; i < GLYPH_H && i < blit_rows; i++) begin
				bits = byte_t'({5'b0, DIGIT_FONT[digit][i]} << col) & mask;
				store[2*i]   = bits | (store[2*i] & ~mask);
				store[2*i+1] = bits | (store[2*i+1] & ~mask);
			end
		endfunction

		function void note_command(command_t c);
			int    g;
			byte_t bit_sel;
			g = 2 * c.row_y;
			bit_sel = byte_t'(8'h01 << c.col_x);
			case (c.cmd)
				CMD_SET_PIXEL: begin
					store[g]   = c.color[0] ? (store[g] | bit_sel) : (store[g] & ~bit_sel);
					store[g+1] = c.color[1] ? (store[g+1] | bit_sel) : (store[g+1] & ~bit_sel);
				end
				CMD_SHIFT_ROW: begin
					store[g]   = store[g] >> 1;
					store[g+1] = store[g+1] >> 1;
				end
				CMD_CLEAR: begin
					foreach (store[i]) store[i] = '0;
				end
				CMD_DRAW_NUMBER: begin
					if (c.number >= 0 && c.number <= NUM_MAX) begin
						blit(int'(c.number) / 10, TENS_COL);
						blit(int'(c.number) % 10, ONES_COL);
					end
				end
				CMD_REFRESH: begin
					pending.push_back('{ADDR_BYTE, 1'b0});
					for (int i = 0; i < STORE_BYTES; i++)
						pending.push_back('{store[i], i == STORE_BYTES - 1});
				end
				default: ;
			endcase
		endfunction

		function void check_byte(byte_t data, logic last);
			stream_byte_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected byte, expected none, actual %h last %b",
						$time, data, last);
				return;
			end
			want = pending.pop_front();
			if (data !== want.data) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want.data, data);
			end
			if (last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, want.last, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bmfb_cmd_if command_ch();
	bmfb_out_if stream_ch();

	frame_scoreboard board;
	bit  hold_request = 1'b0;
	int  idle_cycles = 0;

	bicolor_matrix_frame_buffer_unit #(
		.ROWS(ROWS_TB)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.command(command_ch),
		.stream(stream_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n === 1'b1 && stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1)
			board.check_byte(stream_ch.out_byte, stream_ch.last);
		if ((command_ch.valid === 1'b1 && command_ch.ready === 1'b1) ||
				(stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: changing stall patterns plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       phase;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		phase = 0;
		stream_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				stream_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD - 1;
				stream_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(3, 0));
					mode_left = $urandom_range(150, 20);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  stream_ch.ready <= 1'b1;
					RX_COIN:  stream_ch.ready <= 1'($urandom_range(1, 0));
					RX_THIRD: stream_ch.ready <= (phase % 3 == 0);
					default:  stream_ch.ready <= ($urandom_range(15, 0) != 0);
				endcase
			end
		end
	end

	function automatic command_t make_command(cmd_code_t cmd, coord_t x, coord_t y,
			color_t color, number_t number);
		command_t c;
		c.cmd = cmd;
		c.col_x = x;
		c.row_y = y;
		c.color = color;
		c.number = number;
		return c;
	endfunction

	function automatic command_t random_command();
		command_t c;
		int       pick;
		c.col_x = coord_t'($urandom);
		c.row_y = coord_t'($urandom);
		c.color = color_t'($urandom);
		c.number = number_t'($urandom);
		pick = $urandom_range(99, 0);
		if (pick < 33) begin
			c.cmd = CMD_SET_PIXEL;
		end else if (pick < 45) begin
			c.cmd = CMD_SHIFT_ROW;
		end else if (pick < 48) begin
			c.cmd = CMD_CLEAR;
		end else if (pick < 70) begin
			c.cmd = CMD_DRAW_NUMBER;
			// mostly drawable values, the rest anywhere in the signed range
			if ($urandom_range(4, 0) != 0)
				c.number = number_t'($urandom_range(NUM_MAX, 0));
		end else if (pick < 95) begin
			c.cmd = CMD_REFRESH;
		end else begin
			c.cmd = cmd_code_t'($urandom_range(CMD_UNKNOWN_MAX, CMD_UNKNOWN_MIN));
		end
		return c;
	endfunction

	task automatic send_item(input command_t c);
		command_ch.valid  <= 1'b1;
		command_ch.cmd    <= c.cmd;
		command_ch.col_x  <= c.col_x;
		command_ch.row_y  <= c.row_y;
		command_ch.color  <= c.color;
		command_ch.number <= c.number;
		@(posedge clk);
		while (command_ch.ready !== 1'b1) @(posedge clk);
		board.note_command(c);
	endtask

	task automatic pause_sender(input int cycles);
		command_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		command_t directed[$];
		int       sent;
		int       burst;
		bit       hold_done;
		bit       drain_done;
		board = new(ROWS_TB);
		arst_n = 1'b0;
		command_ch.valid = 1'b0;
		command_ch.cmd = CMD_SET_PIXEL;
		command_ch.col_x = '0;
		command_ch.row_y = '0;
		command_ch.color = COLOR_OFF;
		command_ch.number = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners, every color, shifts, digit extremes, ignored values, unknown codes
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd0, 3'd0, COLOR_ORANGE, 8'sd0));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd7, 3'd7, COLOR_ORANGE, 8'sd0));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd7, 3'd0, COLOR_GREEN, 8'sd0));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd0, 3'd7, COLOR_RED, 8'sd0));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd3, 3'd2, COLOR_ORANGE, 8'sd0));
		directed.push_back(make_command(CMD_REFRESH, 3'd7, 3'd7, COLOR_ORANGE, -8'sd1));
		directed.push_back(make_command(CMD_SET_PIXEL, 3'd7, 3'd7, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_SHIFT_ROW, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_SHIFT_ROW, 3'd0, 3'd7, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd7, 3'd7, COLOR_ORANGE, 8'sd99));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, 8'sd100));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, -8'sd1));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, 8'sh80));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, 8'sd127));
		directed.push_back(make_command(CMD_UNKNOWN_MIN, 3'd1, 3'd1, COLOR_ORANGE, 8'sd5));
		directed.push_back(make_command(CMD_UNKNOWN_MID, 3'd2, 3'd2, COLOR_ORANGE, 8'sd5));
		directed.push_back(make_command(CMD_UNKNOWN_MAX, 3'd7, 3'd7, COLOR_ORANGE, 8'sd5));
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_DRAW_NUMBER, 3'd0, 3'd0, COLOR_OFF, 8'sd57));
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_CLEAR, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		directed.push_back(make_command(CMD_REFRESH, 3'd0, 3'd0, COLOR_OFF, 8'sd0));
		foreach (directed[i]) begin
			send_item(directed[i]);
			if ($urandom_range(2, 0) == 0)
				pause_sender($urandom_range(6, 1));
		end

		sent = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (!hold_done && sent >= RANDOM_ITEMS / 3) begin
				// stall the stream for a long stretch while refreshes keep coming
				hold_done = 1'b1;
				hold_request = 1'b1;
				for (int i = 0; i < 8; i++) begin
					send_item(make_command(CMD_REFRESH, coord_t'($urandom),
						coord_t'($urandom), color_t'($urandom), number_t'($urandom)));
					sent++;
				end
			end
			if (!drain_done && sent >= (2 * RANDOM_ITEMS) / 3) begin
				drain_done = 1'b1;
				command_ch.valid <= 1'b0;
				@(posedge clk);
				while (board.pending.size() != 0) @(posedge clk);
			end
			// occasional long bursts give stretches with no sender gaps
			burst = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_item(random_command());
				sent++;
			end
			if ($urandom_range(3, 0) != 0)
				pause_sender($urandom_range(12, 1));
		end

		command_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
